FILE: sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, codes and constants of the sorted timer deadline queue
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int ID_W          = 5;
  localparam int ID_SLOTS      = 1 << ID_W;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int MS_W          = 32;
  localparam int TS_W          = 48;
  localparam int CNT_OUT_W     = 6;
  localparam int US_PER_MS     = 1000;
  localparam int MUL_W         = 10;
  localparam int PROD_W        = MS_W + MUL_W;
  localparam int NUM_TIMERS_DEF = 32;
  localparam int TIME_BITS_DEF  = 48;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_POLL    = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE        = 2'd0;
  localparam logic [ST_W-1:0] ST_RUNNING     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_RUNNING = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_DUE     = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] timer_id;
    logic [MS_W-1:0] timeout_ms;
    logic [TS_W-1:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic                 expired;
    logic [ID_W-1:0]      expired_id;
    logic                 queue_empty;
    logic [TS_W-1:0]      wait_us;
    logic [CNT_OUT_W-1:0] running_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic ins;
    logic rem;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: sv/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// one position of the sorted list: holds a timer slot and its deadline,
// shifts right to make room on insert and takes its right neighbour on removal
// ----------------------------------------------------------------------------
module stq_cell #(
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stq_pkg::cell_ctl_t        ctl,
  input  logic [stq_pkg::ID_W-1:0]  key_id,
  input  logic [TIME_BITS-1:0]      key_dl,
  input  logic                      lft_valid,
  input  logic [stq_pkg::ID_W-1:0]  lft_id,
  input  logic [TIME_BITS-1:0]      lft_dl,
  input  logic                      rgt_valid,
  input  logic [stq_pkg::ID_W-1:0]  rgt_id,
  input  logic [TIME_BITS-1:0]      rgt_dl,
  input  logic                      g_in,
  input  logic                      r_in,
  output logic                      valid,
  output logic [stq_pkg::ID_W-1:0]  id,
  output logic [TIME_BITS-1:0]      dl,
  output logic                      g_out,
  output logic                      r_out
);

  logic match;

  // stays in place on insert when its deadline is not later than the new one
  assign g_out = valid && (dl <= key_dl);
  // removal point reached at or before this cell
  assign r_out = r_in | (match & ~ctl.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        match <= valid && (id == key_id);
      end
      if (ctl.rem && r_out) begin
        valid <= rgt_valid;
        id    <= rgt_id;
        dl    <= rgt_dl;
      end else if (ctl.ins && !g_out) begin
        if (g_in) begin
          valid <= 1'b1;
          id    <= key_id;
          dl    <= key_dl;
        end else begin
          valid <= lft_valid;
          id    <= lft_id;
          dl    <= lft_dl;
        end
      end
    end
  end

endmodule

FILE: sv/sorted_timer_deadline_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_deadline_queue
// one-shot timers kept in deadline order in a row of list cells
// ----------------------------------------------------------------------------
// cmd channel: one beat per command (start, stop, restart, poll) with the
// current time; rsp channel: exactly one beat per command, in order.
// a start computes now + timeout_ms * 1000 us, saturating at the top of the
// time range, and places the timer behind all timers of equal or earlier
// deadline. a poll expires the head timer when it is due.
// the rsp beat is registered in S_FIN after S_CALC and S_EXEC, and S_INS
// too for a restart of a running timer (a removal pass then an insert pass
// through the cell row). a new command is taken once the previous one has
// been moved into the rsp register, so commands do not overlap. the
// multiply is registered on taking the command, the saturating add in S_CALC,
// the row pass in S_EXEC; the head subtraction feeds the rsp register.
// cmd_stall is high while a command is being worked on; a stalled rsp beat
// holds, and the next command may be taken meanwhile but its beat waits.
// reset empties the list and clears all running flags.
// ----------------------------------------------------------------------------
module sorted_timer_deadline_queue #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  stq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output stq_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int SUM_W = ((TIME_BITS > stq_pkg::PROD_W) ? TIME_BITS : stq_pkg::PROD_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                     state;
  logic [stq_pkg::OP_W-1:0]       op_q;
  logic [stq_pkg::ID_W-1:0]       id_q;
  logic [TIME_BITS-1:0]           now_q;
  logic [stq_pkg::PROD_W-1:0]     prod_q;
  logic [TIME_BITS-1:0]           dl_q;
  logic                           hit_q;
  logic                           bad_q;
  logic                           due_q;
  logic [stq_pkg::ST_W-1:0]       st_q;
  logic                           exp_q;
  logic [stq_pkg::ID_W-1:0]       exp_id_q;
  logic [CNT_W-1:0]               cnt;
  logic [stq_pkg::ID_SLOTS-1:0]   running;

  stq_pkg::cell_ctl_t             ctl;
  logic                           room;
  logic [SUM_W-1:0]               sum;
  logic [TIME_BITS-1:0]           sat_dl;
  logic [TIME_BITS-1:0]           wait_t;

  logic                           cv  [0:NUM_TIMERS+1];
  logic [stq_pkg::ID_W-1:0]       cid [0:NUM_TIMERS+1];
  logic [TIME_BITS-1:0]           cdl [0:NUM_TIMERS+1];
  logic                           g   [0:NUM_TIMERS];
  logic                           r   [0:NUM_TIMERS];

  // ends of the row
  assign cv[0]             = 1'b0;
  assign cid[0]            = '0;
  assign cdl[0]            = '0;
  assign cv[NUM_TIMERS+1]  = 1'b0;
  assign cid[NUM_TIMERS+1] = '0;
  assign cdl[NUM_TIMERS+1] = '0;
  assign g[0]              = 1'b1;
  assign r[0]              = ctl.pop;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .key_id    (id_q),
      .key_dl    (dl_q),
      .lft_valid (cv[i]),
      .lft_id    (cid[i]),
      .lft_dl    (cdl[i]),
      .rgt_valid (cv[i+2]),
      .rgt_id    (cid[i+2]),
      .rgt_dl    (cdl[i+2]),
      .g_in      (g[i]),
      .r_in      (r[i]),
      .valid     (cv[i+1]),
      .id        (cid[i+1]),
      .dl        (cdl[i+1]),
      .g_out     (g[i+1]),
      .r_out     (r[i+1])
    );
  end

  assign cmd_stall = (state != S_IDLE);
  assign room      = (cnt < CNT_W'(NUM_TIMERS));

  always_comb begin
    sum    = SUM_W'(now_q) + SUM_W'(prod_q);
    sat_dl = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);
    wait_t = (cv[1] && (cdl[1] > now_q)) ? (cdl[1] - now_q) : '0;
  end

  always_comb begin
    ctl = '0;
    case (state)
      S_CALC: begin
        ctl.load = 1'b1;
      end
      S_EXEC: begin
        case (op_q)
          stq_pkg::OP_POLL: begin
            ctl.rem = due_q;
            ctl.pop = due_q;
          end
          stq_pkg::OP_START: begin
            ctl.ins = !bad_q && !hit_q && room;
          end
          stq_pkg::OP_STOP: begin
            ctl.rem = !bad_q && hit_q;
          end
          stq_pkg::OP_RESTART: begin
            ctl.rem = !bad_q && hit_q;
            ctl.ins = !bad_q && !hit_q && room;
          end
          default: begin
            ctl = '0;
          end
        endcase
      end
      S_INS: begin
        ctl.ins = room;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      running <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_q   <= cmd.op;
            id_q   <= cmd.timer_id;
            now_q  <= TIME_BITS'(cmd.now_us);
            prod_q <= stq_pkg::PROD_W'(cmd.timeout_ms) *
                      stq_pkg::PROD_W'(stq_pkg::US_PER_MS);
            state  <= S_CALC;
          end
        end
        S_CALC: begin
          dl_q  <= sat_dl;
          hit_q <= running[id_q];
          bad_q <= (32'(id_q) >= 32'(NUM_TIMERS));
          due_q <= cv[1] && (cdl[1] <= now_q);
          state <= S_EXEC;
        end
        S_EXEC: begin
          st_q     <= stq_pkg::ST_DONE;
          exp_q    <= 1'b0;
          exp_id_q <= '0;
          state    <= S_FIN;
          if (op_q == stq_pkg::OP_POLL) begin
            if (due_q) begin
              exp_q             <= 1'b1;
              exp_id_q          <= cid[1];
              running[cid[1]]   <= 1'b0;
              cnt               <= cnt - 1'b1;
            end else begin
              st_q <= stq_pkg::ST_NOT_DUE;
            end
          end else if (bad_q) begin
            st_q <= stq_pkg::ST_NOT_RUNNING;
          end else begin
            case (op_q)
              stq_pkg::OP_START: begin
                if (hit_q) begin
                  st_q <= stq_pkg::ST_RUNNING;
                end else if (room) begin
                  running[id_q] <= 1'b1;
                  cnt           <= cnt + 1'b1;
                end
              end
              stq_pkg::OP_STOP: begin
                if (hit_q) begin
                  running[id_q] <= 1'b0;
                  cnt           <= cnt - 1'b1;
                end else begin
                  st_q <= stq_pkg::ST_NOT_RUNNING;
                end
              end
              stq_pkg::OP_RESTART: begin
                if (hit_q) begin
                  running[id_q] <= 1'b0;
                  cnt           <= cnt - 1'b1;
                  state         <= S_INS;
                end else if (room) begin
                  running[id_q] <= 1'b1;
                  cnt           <= cnt + 1'b1;
                end
              end
              default: begin
                st_q <= stq_pkg::ST_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (room) begin
            running[id_q] <= 1'b1;
            cnt           <= cnt + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status        <= st_q;
            rsp.expired       <= exp_q;
            rsp.expired_id    <= exp_id_q;
            rsp.queue_empty   <= !cv[1];
            rsp.wait_us       <= stq_pkg::TS_W'(wait_t);
            rsp.running_count <= stq_pkg::CNT_OUT_W'(cnt);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // an insert always finds a free cell at the tail
  assert property (@(posedge clk) disable iff (rst) ctl.ins |-> !g[NUM_TIMERS])
    else $error("insert found no free cell");

  // removing a running timer by slot finds it in the row
  assert property (@(posedge clk) disable iff (rst)
      (ctl.rem && !ctl.pop) |-> r[NUM_TIMERS])
    else $error("running timer missing from the list");

  // fill count agrees with the head cell
  assert property (@(posedge clk) disable iff (rst) (cnt == '0) == !cv[1])
    else $error("fill count and list disagree");

  // an expiry is only reported with done status
  assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> (!rsp.expired || rsp.status == stq_pkg::ST_DONE))
    else $error("expiry beat with wrong status");

endmodule
